### rtl/tfe_pkg.sv
// Shared constants, field layout and types of the triangle fragment evaluator.
`default_nettype none

package tfe_pkg;

    localparam int COORD_FRAC_BITS = 4;
    localparam int SCREEN_MAX      = 2048;
    localparam int TEXTURE_MAX     = 4096;

    localparam int COORD_W    = 16;
    localparam int Z_W        = 16;
    localparam int PIX_W      = 11;
    localparam int TEX_W      = 13;
    localparam int TXC_W      = 12;
    localparam int IDX_W      = 24;
    localparam int CFG_ADDR_W = 1;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 88;

    localparam int PX_LSB = 9 * COORD_W;
    localparam int PY_LSB = PX_LSB + PIX_W;

    localparam int O_PX_LSB    = 0;
    localparam int O_PY_LSB    = O_PX_LSB + PIX_W;
    localparam int O_DEPTH_LSB = O_PY_LSB + PIX_W;
    localparam int O_TX_LSB    = O_DEPTH_LSB + Z_W;
    localparam int O_TY_LSB    = O_TX_LSB + TXC_W;
    localparam int O_IDX_LSB   = O_TY_LSB + TXC_W;

    localparam int COORD2_W = COORD_W + 1;
    localparam int PC_W     = PIX_W + 2 + COORD_FRAC_BITS;
    localparam int SUB_W    = (PC_W > COORD2_W) ? PC_W : COORD2_W;
    localparam int DIF_W    = SUB_W + 1;
    localparam int PROD_W   = 2 * DIF_W;
    localparam int EDGE_W   = PROD_W + 1;
    localparam int U_W      = EDGE_W - 1;
    localparam int MZ_W     = Z_W + U_W;
    localparam int MT_W     = U_W + TXC_W;
    localparam int DNUM_W   = MZ_W + 2;
    localparam int QUO_W    = Z_W;

    localparam logic [CFG_ADDR_W-1:0] REG_TEX_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_TEX_HEIGHT = 1'b1;

    typedef struct packed {
        logic             textured;
        logic             covered;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
    } t_side;

endpackage

`default_nettype wire

### rtl/tfe_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module tfe_div_pipe #(
    parameter int NUM_W = 54,
    parameter int DEN_W = 36,
    parameter int QUO_W = 16
) (
    input  wire logic             i_clk,
    input  wire logic [QUO_W-1:0] i_adv,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic      [QUO_W-1:0] o_quo
);

    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [CMP_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic [CMP_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [QUO_W-1:0] w_quo_in;
        logic [CMP_W-1:0] w_sub;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = CMP_W'(i_num);
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_sub = CMP_W'(w_den_in) << (QUO_W - 1 - k);
        assign w_ge  = (w_rem_in >= w_sub);

        always_ff @(posedge i_clk) begin
            if (i_adv[k]) begin
                r_rem[k] <= w_ge ? (w_rem_in - w_sub) : w_rem_in;
                r_den[k] <= w_den_in;
                r_quo[k] <= w_quo_in | (QUO_W'(w_ge) << (QUO_W - 1 - k));
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

`default_nettype wire

### rtl/triangle_fragment_evaluator.sv
// Top level: edge-function coverage, depth and texel evaluation for one pixel per word.
//
//  channel  dir  handshake               payload
//  s        in   i_s_tvalid/o_s_tready   i_s_tdata (vertices, pixel), i_s_tuser (mode)
//  m        out  o_m_tvalid/i_m_tready   o_m_tdata (pixel, depth, texel), o_m_tuser (covered)
//  cfg      in   i_cfg_valid/o_cfg_ready i_cfg_addr, i_cfg_data (texture width/height)
//
//  One word per cycle while m does not stall; the 16-stage quotient pipeline makes up most of the pipeline.
//  Reset clears the stage valid bits and both texture size registers.
//  A stall on m fills empty stages first; o_s_tready drops only when every stage holds a word.
`default_nettype none

module triangle_fragment_evaluator
    import tfe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, pixel_x, pixel_y, zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // mode
    input  wire logic                  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // out_pixel_x, out_pixel_y, depth, texel_x, texel_y, texel_index, zero pad
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    // covered
    output logic                       o_m_tuser,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [TEX_W-1:0]      i_cfg_data
);

    localparam int ST_DIV0 = 6;
    localparam int NST     = ST_DIV0 + QUO_W + 1;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;
    t_side          r_side [NST];
    t_side          n_side [NST];

    logic [TEX_W-1:0] r_tex_w, r_tex_h;
    logic [TEX_W-1:0] w_tw, w_th;
    logic [TXC_W-1:0] w_twm1, w_thm1;

    logic signed [SUB_W-1:0] w_vx [3];
    logic signed [SUB_W-1:0] w_vy [3];
    logic signed [SUB_W-1:0] w_pcx, w_pcy;
    logic [2:0][Z_W-1:0]     w_zin;

    logic signed [DIF_W-1:0]  r_d0 [16];
    logic signed [DIF_W-1:0]  n_d0 [16];
    logic [2:0][Z_W-1:0]      r_z  [4];
    logic signed [PROD_W-1:0] r_p1 [8];
    logic signed [EDGE_W-1:0] r_e2 [4];
    logic [U_W-1:0]           r_u3 [4];
    logic [U_W-1:0]           n_u3 [4];
    logic                     n_cov;
    logic [MZ_W-1:0]          r_mz4 [3];
    logic [MT_W-1:0]          r_mt4 [2];
    logic [U_W-1:0]           r_den4, r_den5;
    logic [DNUM_W-1:0]        r_dnum5;
    logic [MT_W-1:0]          r_tnum5 [2];

    logic [QUO_W-1:0] w_q_depth, w_q_tx, w_q_ty;
    logic [TXC_W-1:0] w_tx12, w_ty12;
    logic [TXC_W+TEX_W-1:0] w_tprod;
    logic [Z_W-1:0]   r_depth;
    logic [TXC_W-1:0] r_tx, r_ty;
    logic [IDX_W-1:0] r_idx;

    function automatic logic signed [DIF_W-1:0] f_sub(input logic signed [SUB_W-1:0] a,
                                                      input logic signed [SUB_W-1:0] b);
        return DIF_W'(a) - DIF_W'(b);
    endfunction

    always_comb begin
        for (int k = 0; k < NST; k++) begin
            w_adv[k] = i_m_tready || ((r_vld | ((NST'(1) << k) - NST'(1))) != '1);
        end
    end

    assign o_s_tready  = w_adv[0];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= '0;
            r_tex_h <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_TEX_WIDTH:  r_tex_w <= i_cfg_data;
                REG_TEX_HEIGHT: r_tex_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_tw   = (r_tex_w > TEX_W'(TEXTURE_MAX)) ? TEX_W'(TEXTURE_MAX) : r_tex_w;
    assign w_th   = (r_tex_h > TEX_W'(TEXTURE_MAX)) ? TEX_W'(TEXTURE_MAX) : r_tex_h;
    assign w_twm1 = TXC_W'(w_tw - TEX_W'(1));
    assign w_thm1 = TXC_W'(w_th - TEX_W'(1));

    always_comb begin
        for (int v = 0; v < 3; v++) begin
            w_vx[v]  = SUB_W'($signed({i_s_tdata[v*3*COORD_W +: COORD_W], 1'b0}));
            w_vy[v]  = SUB_W'($signed({i_s_tdata[v*3*COORD_W + COORD_W +: COORD_W], 1'b0}));
            w_zin[v] = i_s_tdata[v*3*COORD_W + 2*COORD_W +: Z_W];
        end
        w_pcx = SUB_W'($signed({1'b0, i_s_tdata[PX_LSB +: PIX_W], 1'b1,
                                {COORD_FRAC_BITS{1'b0}}}));
        w_pcy = SUB_W'($signed({1'b0, i_s_tdata[PY_LSB +: PIX_W], 1'b1,
                                {COORD_FRAC_BITS{1'b0}}}));

        n_d0[0]  = f_sub(w_vx[2], w_vx[0]);
        n_d0[1]  = f_sub(w_vy[1], w_vy[0]);
        n_d0[2]  = f_sub(w_vy[2], w_vy[0]);
        n_d0[3]  = f_sub(w_vx[1], w_vx[0]);
        n_d0[4]  = f_sub(w_pcx,   w_vx[1]);
        n_d0[5]  = f_sub(w_vy[2], w_vy[1]);
        n_d0[6]  = f_sub(w_pcy,   w_vy[1]);
        n_d0[7]  = f_sub(w_vx[2], w_vx[1]);
        n_d0[8]  = f_sub(w_pcx,   w_vx[2]);
        n_d0[9]  = f_sub(w_vy[0], w_vy[2]);
        n_d0[10] = f_sub(w_pcy,   w_vy[2]);
        n_d0[11] = f_sub(w_vx[0], w_vx[2]);
        n_d0[12] = f_sub(w_pcx,   w_vx[0]);
        n_d0[13] = f_sub(w_vy[1], w_vy[0]);
        n_d0[14] = f_sub(w_pcy,   w_vy[0]);
        n_d0[15] = f_sub(w_vx[1], w_vx[0]);
    end

    always_comb begin
        n_cov = (r_e2[0] != '0)
             && (32'(r_side[2].px) < SCREEN_MAX) && (32'(r_side[2].py) < SCREEN_MAX)
             && ((r_e2[1] >= 0 && r_e2[2] >= 0 && r_e2[3] >= 0)
              || (r_e2[1] <= 0 && r_e2[2] <= 0 && r_e2[3] <= 0))
             && (!r_side[2].textured || (w_tw != '0 && w_th != '0));
        for (int j = 0; j < 4; j++) begin
            n_u3[j] = U_W'((r_e2[0] < 0) ? -r_e2[j] : r_e2[j]);
        end
    end

    always_comb begin
        n_side[0].textured = i_s_tuser;
        n_side[0].covered  = 1'b0;
        n_side[0].px       = i_s_tdata[PX_LSB +: PIX_W];
        n_side[0].py       = i_s_tdata[PY_LSB +: PIX_W];
        for (int k = 1; k < NST; k++) begin
            n_side[k] = r_side[k-1];
        end
        n_side[3].covered = n_cov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NST; k++) begin
            if (w_adv[k]) begin
                r_side[k] <= n_side[k];
            end
        end
        if (w_adv[0]) begin
            r_d0    <= n_d0;
            r_z[0]  <= w_zin;
        end
        for (int k = 1; k < 4; k++) begin
            if (w_adv[k]) begin
                r_z[k] <= r_z[k-1];
            end
        end
        if (w_adv[1]) begin
            for (int j = 0; j < 8; j++) begin
                r_p1[j] <= PROD_W'(r_d0[2*j]) * PROD_W'(r_d0[2*j+1]);
            end
        end
        if (w_adv[2]) begin
            for (int j = 0; j < 4; j++) begin
                r_e2[j] <= EDGE_W'(r_p1[2*j]) - EDGE_W'(r_p1[2*j+1]);
            end
        end
        if (w_adv[3]) begin
            r_u3 <= n_u3;
        end
        if (w_adv[4]) begin
            for (int j = 0; j < 3; j++) begin
                r_mz4[j] <= MZ_W'(r_z[3][j]) * MZ_W'(r_u3[j+1]);
            end
            r_mt4[0] <= MT_W'(r_u3[2]) * MT_W'(w_twm1);
            r_mt4[1] <= MT_W'(r_u3[3]) * MT_W'(w_thm1);
            r_den4   <= r_u3[0];
        end
        if (w_adv[5]) begin
            r_dnum5 <= DNUM_W'(r_mz4[0]) + DNUM_W'(r_mz4[1]) + DNUM_W'(r_mz4[2]);
            r_tnum5 <= r_mt4;
            r_den5  <= r_den4;
        end
        if (w_adv[NST-1]) begin
            r_depth <= r_side[NST-2].covered ? w_q_depth : '0;
            if (r_side[NST-2].covered && r_side[NST-2].textured) begin
                r_tx  <= w_tx12;
                r_ty  <= w_ty12;
                r_idx <= IDX_W'(w_tprod + (TXC_W+TEX_W)'(w_tx12));
            end else begin
                r_tx  <= '0;
                r_ty  <= '0;
                r_idx <= '0;
            end
        end
    end

    tfe_div_pipe #(.NUM_W(DNUM_W), .DEN_W(U_W), .QUO_W(QUO_W)) u_div_depth (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_DIV0 +: QUO_W]),
        .i_num (r_dnum5),
        .i_den (r_den5),
        .o_quo (w_q_depth)
    );

    tfe_div_pipe #(.NUM_W(MT_W), .DEN_W(U_W), .QUO_W(QUO_W)) u_div_tx (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_DIV0 +: QUO_W]),
        .i_num (r_tnum5[0]),
        .i_den (r_den5),
        .o_quo (w_q_tx)
    );

    tfe_div_pipe #(.NUM_W(MT_W), .DEN_W(U_W), .QUO_W(QUO_W)) u_div_ty (
        .i_clk (i_clk),
        .i_adv (w_adv[ST_DIV0 +: QUO_W]),
        .i_num (r_tnum5[1]),
        .i_den (r_den5),
        .o_quo (w_q_ty)
    );

    assign w_tx12  = w_q_tx[TXC_W-1:0];
    assign w_ty12  = w_q_ty[TXC_W-1:0];
    assign w_tprod = (TXC_W+TEX_W)'(w_ty12) * (TXC_W+TEX_W)'(w_tw);

    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tuser  = r_side[NST-1].covered;
    assign o_m_tdata  = {(OUT_DATA_W-O_IDX_LSB-IDX_W)'(0), r_idx, r_ty, r_tx, r_depth,
                         r_side[NST-1].py, r_side[NST-1].px};

`ifndef SYNTH
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> r_depth == '0 && r_tx == '0 && r_idx == '0)
        else $error("uncovered word carries nonzero depth or texel");

    a_flat_no_texel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !r_side[NST-1].textured |-> r_tx == '0 && r_ty == '0 && r_idx == '0)
        else $error("flat word carries texel data");

    a_texel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser && r_side[NST-1].textured
            |-> TEX_W'(r_tx) < w_tw && TEX_W'(r_ty) < w_th)
        else $error("texel coordinate outside texture");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !i_m_tready |-> !o_s_tready)
        else $error("input taken while pipeline full and stalled");
`endif

endmodule

`default_nettype wire
